// ----- hdl/nmk_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Newmark update unit.
`timescale 1ns / 1ps
`default_nettype none
package nmk_pkg;

    // Value format Q24.24, coefficient format Q8.40
    localparam int VALUE_BITS = 48;
    localparam int COEF_BITS  = 48;
    localparam int LIMIT_BITS = COEF_BITS - 1;
    localparam int FRAC_SHIFT = 40;

    // Product magnitude after rounding shift, one spare bit
    localparam int PROD_W = VALUE_BITS + COEF_BITS + 1;
    localparam int MAG_W  = PROD_W - FRAC_SHIFT;

    localparam int FIFO_DEPTH = 4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PRED_DV = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRED_DA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRED_VA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_DA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_VA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd5;

    typedef logic signed [VALUE_BITS-1:0] val_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;

    localparam val_t VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam val_t VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        CMD_PREDICT  = 3'd0,
        CMD_CORRECT  = 3'd1,
        CMD_TOTAL    = 3'd2,
        CMD_SET_DISP = 3'd3,
        CMD_SET_VEL  = 3'd4,
        CMD_SET_ACC  = 3'd5,
        CMD_HOLD     = 3'd6,
        CMD_UNKNOWN  = 3'd7
    } cmd_t;

    typedef struct packed {
        coef_t                 pred_dv;
        coef_t                 pred_da;
        coef_t                 pred_va;
        coef_t                 corr_da;
        coef_t                 corr_va;
        logic [LIMIT_BITS-1:0] small_limit;
    } cfg_t;

    // Work plan for one item, built by the front end
    typedef struct packed {
        val_t                  d_base;
        val_t                  v_base;
        val_t                  a_fix;
        val_t                  op0;
        val_t                  op1;
        val_t                  op2;
        coef_t                 c0;
        coef_t                 c1;
        coef_t                 c2;
        logic                  needs_div;
        logic                  div_sel;   // 1: quotient feeds lane 0, else lane 2
        logic                  q_neg;
        logic [VALUE_BITS:0]   num;
        logic [COEF_BITS-1:0]  dv;
        logic                  bad;
    } plan_t;

    // Saturating add of two values
    function automatic val_t sat_add(input val_t a, input val_t b);
        logic [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            return s[VALUE_BITS] ? VMIN : VMAX;
        end
        return val_t'(s[VALUE_BITS-1:0]);
    endfunction

    // Saturating difference a - b
    function automatic val_t sat_sub(input val_t a, input val_t b);
        logic [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            return s[VALUE_BITS] ? VMIN : VMAX;
        end
        return val_t'(s[VALUE_BITS-1:0]);
    endfunction

    function automatic logic [VALUE_BITS-1:0] vmag(input val_t x);
        return x[VALUE_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [COEF_BITS-1:0] cmag(input coef_t x);
        return x[COEF_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    // Apply a sign to a magnitude, saturating to the value range
    function automatic val_t from_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] top;
        top = {{(MAG_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
        if (!neg) begin
            return (mag > top) ? VMAX : val_t'(mag[VALUE_BITS-1:0]);
        end
        if (mag > top + MAG_W'(1)) begin
            return VMIN;
        end
        return val_t'(~mag[VALUE_BITS-1:0] + 1'b1);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/nmk_front.sv -----
// Front end: decode the command and build the work plan for one item.
`timescale 1ns / 1ps
`default_nettype none
module nmk_front (
    input  wire nmk_pkg::cmd_t  command,
    input  wire nmk_pkg::val_t  displacement_in,
    input  wire nmk_pkg::val_t  velocity_in,
    input  wire nmk_pkg::val_t  acceleration_in,
    input  wire nmk_pkg::val_t  operand_value,
    input  wire nmk_pkg::cfg_t  cfg,
    output nmk_pkg::plan_t      plan
);
    import nmk_pkg::*;

    val_t                  d, v, a, x, y;
    coef_t                 c;
    logic [VALUE_BITS:0]   diff;
    logic [COEF_BITS-1:0]  dv;
    logic                  div_ok;

    assign d = displacement_in;
    assign v = velocity_in;
    assign a = acceleration_in;
    assign x = operand_value;

    // Back-solve operands: exact difference and divisor magnitude
    always_comb begin
        if (command == CMD_SET_DISP) begin
            y = d;
            c = cfg.corr_da;
        end else begin
            y = v;
            c = cfg.corr_va;
        end
        diff   = {x[VALUE_BITS-1], x} - {y[VALUE_BITS-1], y};
        dv     = cmag(c);
        div_ok = dv > COEF_BITS'(cfg.small_limit);
    end

    // Route values and coefficients per command
    always_comb begin
        plan           = '0;
        plan.d_base    = d;
        plan.v_base    = v;
        plan.a_fix     = a;
        plan.num       = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;
        plan.dv        = dv;
        plan.q_neg     = diff[VALUE_BITS] ^ c[COEF_BITS-1];
        case (command)
            CMD_PREDICT: begin
                plan.op0   = v;
                plan.c0    = cfg.pred_dv;
                plan.op1   = a;
                plan.c1    = cfg.pred_da;
                plan.op2   = a;
                plan.c2    = cfg.pred_va;
                plan.a_fix = '0;
            end
            CMD_CORRECT: begin
                plan.op0   = x;
                plan.c0    = cfg.corr_da;
                plan.op2   = x;
                plan.c2    = cfg.corr_va;
                plan.a_fix = sat_add(a, x);
            end
            CMD_TOTAL: begin
                plan.op0   = sat_sub(x, a);
                plan.c0    = cfg.corr_da;
                plan.op2   = sat_sub(x, a);
                plan.c2    = cfg.corr_va;
                plan.a_fix = x;
            end
            CMD_SET_DISP: begin
                plan.d_base    = x;
                plan.c2        = cfg.corr_va;
                plan.a_fix     = '0;
                plan.needs_div = div_ok;
                plan.div_sel   = 1'b0;
            end
            CMD_SET_VEL: begin
                plan.v_base    = x;
                plan.c0        = cfg.corr_da;
                plan.a_fix     = '0;
                plan.needs_div = div_ok;
                plan.div_sel   = 1'b1;
            end
            CMD_SET_ACC: begin
                plan.op0   = x;
                plan.c0    = cfg.corr_da;
                plan.op2   = x;
                plan.c2    = cfg.corr_va;
                plan.a_fix = x;
            end
            CMD_HOLD: begin
                plan.a_fix = a;
            end
            default: begin
                plan.bad = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/nmk_fifo.sv -----
// Short plan queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module nmk_fifo (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             wr_en,
    input  wire nmk_pkg::plan_t wr_plan,
    output logic            full,
    input  wire             rd_en,
    output logic            head_valid,
    output nmk_pkg::plan_t  head_plan
);
    import nmk_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    plan_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_plan  = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_plan;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/nmk_back.sv -----
// Back end: back-solve divider, three multiply lanes and saturating sums.
`timescale 1ns / 1ps
`default_nettype none
module nmk_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              head_valid,
    input  wire nmk_pkg::plan_t head_plan,
    output logic             pop,
    output logic             m_valid,
    input  wire              m_ready,
    output nmk_pkg::val_t    d_out,
    output nmk_pkg::val_t    v_out,
    output nmk_pkg::val_t    a_out,
    output logic             bad_out
);
    import nmk_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int CB    = COEF_BITS;
    localparam int AH    = VB / 2;
    localparam int CH    = CB / 2;
    localparam int DIV_W = VB + 1 + FRAC_SHIFT + CB;
    localparam int CNT_W = $clog2(VB + 1);

    typedef enum logic [3:0] {
        DIV_IDLE  = 4'b0001,
        DIV_RUN   = 4'b0010,
        DIV_ROUND = 4'b0100,
        DIV_DONE  = 4'b1000
    } div_state_t;

    typedef struct packed {
        val_t d_base;
        val_t v_base;
        val_t a_val;
        logic bad;
    } carry_t;

    // Divider state
    div_state_t         div_state_reg, div_state_next;
    logic [CB-2:0]      rem_reg;
    logic [VB:0]        quo_reg;
    logic [VB:0]        dbits_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               ovf_reg;
    val_t               qv_reg;

    logic [DIV_W-1:0]   dw, dvs;
    logic [CB-1:0]      r2;
    logic               r_ge;
    logic [VB+1:0]      q_round;

    logic               en, issue;
    val_t               op0_sel, op2_sel, a_sel;

    // Pipeline registers
    logic               s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [2:0]         s0_neg_reg, s1_neg_reg;
    logic [VB-1:0]      s0_amag_reg [3];
    logic [CB-1:0]      s0_cmag_reg [3];
    logic [AH+CH-1:0]           pp00_reg [3];
    logic [AH+CB-CH-1:0]        pp01_reg [3];
    logic [VB-AH+CH-1:0]        pp10_reg [3];
    logic [VB-AH+CB-CH-1:0]     pp11_reg [3];
    val_t               s2_p_reg [3];
    val_t               s3_d_reg, s3_v_reg, s3_p1_reg;
    carry_t             s0_c_reg, s1_c_reg, s2_c_reg, s3_c_reg;
    val_t               d_out_reg, v_out_reg, a_out_reg;
    logic               bad_out_reg;
    logic [PROD_W-1:0]  psum [3];

    assign en    = !out_valid_reg || m_ready;
    assign issue = head_valid && en && (!head_plan.needs_div || div_state_reg == DIV_DONE);
    assign pop   = issue;

    // Divider operands at start
    assign dw   = DIV_W'(head_plan.num) << FRAC_SHIFT;
    assign dvs  = DIV_W'(head_plan.dv) << (VB + 1);
    assign r2   = {rem_reg, dbits_reg[VB]};
    assign r_ge = (r2 >= head_plan.dv);
    assign q_round = {1'b0, quo_reg} + (VB+2)'({rem_reg, 1'b0} >= head_plan.dv);

    // Divider sequencing
    always_comb begin
        div_state_next = div_state_reg;
        case (div_state_reg)
            DIV_IDLE: begin
                if (head_valid && head_plan.needs_div) begin
                    div_state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (cnt_reg == '0) begin
                    div_state_next = DIV_ROUND;
                end
            end
            DIV_ROUND: begin
                div_state_next = DIV_DONE;
            end
            DIV_DONE: begin
                if (issue) begin
                    div_state_next = DIV_IDLE;
                end
            end
            default: begin
                div_state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_state_reg <= DIV_IDLE;
        end else begin
            div_state_reg <= div_state_next;
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (div_state_reg == DIV_IDLE) begin
            rem_reg   <= (CB-1)'(dw >> (VB + 1));
            dbits_reg <= dw[VB:0];
            quo_reg   <= '0;
            cnt_reg   <= CNT_W'(VB);
            ovf_reg   <= (dw >= dvs);
        end else if (div_state_reg == DIV_RUN) begin
            rem_reg   <= r_ge ? (CB-1)'(r2 - head_plan.dv) : r2[CB-2:0];
            quo_reg   <= {quo_reg[VB-1:0], r_ge};
            dbits_reg <= {dbits_reg[VB-1:0], 1'b0};
            cnt_reg   <= cnt_reg - 1'b1;
        end else if (div_state_reg == DIV_ROUND) begin
            qv_reg <= from_mag(head_plan.q_neg, ovf_reg ? {MAG_W{1'b1}} : MAG_W'(q_round));
        end
    end

    // Substitute the quotient where the plan asks for it
    always_comb begin
        op0_sel = head_plan.op0;
        op2_sel = head_plan.op2;
        a_sel   = head_plan.a_fix;
        if (head_plan.needs_div) begin
            a_sel = qv_reg;
            if (head_plan.div_sel) begin
                op0_sel = qv_reg;
            end else begin
                op2_sel = qv_reg;
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg  <= issue;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Product sums with rounding bias
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            psum[i] = PROD_W'(pp00_reg[i]) + (PROD_W'(pp10_reg[i]) << AH)
                    + (PROD_W'(pp01_reg[i]) << CH) + (PROD_W'(pp11_reg[i]) << (AH + CH))
                    + (PROD_W'(1) << (FRAC_SHIFT - 1));
        end
    end

    // Payload pipeline: magnitudes, partial products, round, two sums
    always_ff @(posedge aclk) begin
        if (en) begin
            s0_neg_reg[0]  <= op0_sel[VB-1] ^ head_plan.c0[CB-1];
            s0_neg_reg[1]  <= head_plan.op1[VB-1] ^ head_plan.c1[CB-1];
            s0_neg_reg[2]  <= op2_sel[VB-1] ^ head_plan.c2[CB-1];
            s0_amag_reg[0] <= vmag(op0_sel);
            s0_amag_reg[1] <= vmag(head_plan.op1);
            s0_amag_reg[2] <= vmag(op2_sel);
            s0_cmag_reg[0] <= cmag(head_plan.c0);
            s0_cmag_reg[1] <= cmag(head_plan.c1);
            s0_cmag_reg[2] <= cmag(head_plan.c2);
            s0_c_reg       <= '{d_base: head_plan.d_base, v_base: head_plan.v_base,
                                a_val: a_sel, bad: head_plan.bad};

            for (int i = 0; i < 3; i++) begin
                pp00_reg[i] <= s0_amag_reg[i][AH-1:0] * s0_cmag_reg[i][CH-1:0];
                pp01_reg[i] <= s0_amag_reg[i][AH-1:0] * s0_cmag_reg[i][CB-1:CH];
                pp10_reg[i] <= s0_amag_reg[i][VB-1:AH] * s0_cmag_reg[i][CH-1:0];
                pp11_reg[i] <= s0_amag_reg[i][VB-1:AH] * s0_cmag_reg[i][CB-1:CH];
            end
            s1_neg_reg <= s0_neg_reg;
            s1_c_reg   <= s0_c_reg;

            for (int i = 0; i < 3; i++) begin
                s2_p_reg[i] <= from_mag(s1_neg_reg[i], psum[i][PROD_W-1:FRAC_SHIFT]);
            end
            s2_c_reg <= s1_c_reg;

            s3_d_reg  <= sat_add(s2_c_reg.d_base, s2_p_reg[0]);
            s3_v_reg  <= sat_add(s2_c_reg.v_base, s2_p_reg[2]);
            s3_p1_reg <= s2_p_reg[1];
            s3_c_reg  <= s2_c_reg;

            d_out_reg   <= sat_add(s3_d_reg, s3_p1_reg);
            v_out_reg   <= s3_v_reg;
            a_out_reg   <= s3_c_reg.a_val;
            bad_out_reg <= s3_c_reg.bad;
        end
    end

    assign m_valid = out_valid_reg;
    assign d_out   = d_out_reg;
    assign v_out   = v_out_reg;
    assign a_out   = a_out_reg;
    assign bad_out = bad_out_reg;

    // The item being divided stays at the queue head
    a_div_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_state_reg == DIV_RUN) |-> (head_valid && head_plan.needs_div))
        else $error("divider running without a dividing item at the head");

    // A finished quotient waits until its item issues
    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_state_reg == DIV_DONE && !issue) |=> (div_state_reg == DIV_DONE))
        else $error("quotient dropped before issue");

    // A dividing item issues only with its quotient ready
    a_div_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && head_plan.needs_div) |-> (div_state_reg == DIV_DONE))
        else $error("dividing item issued early");

    // Pipeline moves forward when enabled
    a_pipe_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s0_valid_reg && en) |=> s1_valid_reg)
        else $error("item lost between stages");

endmodule
`default_nettype wire

// ----- hdl/newmark_dof_update_unit.sv -----
// Top level of the Newmark degree-of-freedom update unit.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  tuser: command; tdata: d, v, a, operand
//  m_        out        m_tvalid / m_tready  tuser: bad_command; tdata: d, v, a
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// Most commands pass the queue, s0-s3 and output registers; one item a cycle unless
// m_tready stalls. Set-displacement and set-velocity with a coefficient magnitude above
// small_limit use the shared bit-serial back-solve divider; items behind wait in order.
// Reset is synchronous, active low; it clears the queue, divider and valid bits.
// A stalled result freezes the back-end pipeline; the queue keeps accepting until it fills.
`timescale 1ns / 1ps
`default_nettype none
module newmark_dof_update_unit (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // tdata: displacement_in, velocity_in, acceleration_in, operand_value
    input  wire  [4*nmk_pkg::VALUE_BITS-1:0]   s_tdata,
    // tuser: command
    input  wire  [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // tdata: displacement_out, velocity_out, acceleration_out
    output logic [3*nmk_pkg::VALUE_BITS-1:0]   m_tdata,
    // tuser: bad_command
    output logic [0:0]                         m_tuser,
    input  wire                                cfg_wr_en,
    input  wire  [nmk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [nmk_pkg::COEF_BITS-1:0]      cfg_wdata
);
    import nmk_pkg::*;

    localparam int VB = VALUE_BITS;

    cfg_t   cfg_reg, cfg_next;
    plan_t  plan, head_plan;
    logic   full, head_valid, pop, wr_en;
    val_t   d_out, v_out, a_out;
    logic   bad_out;

    // Configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PRED_DV: cfg_next.pred_dv     = coef_t'(cfg_wdata);
                REG_PRED_DA: cfg_next.pred_da     = coef_t'(cfg_wdata);
                REG_PRED_VA: cfg_next.pred_va     = coef_t'(cfg_wdata);
                REG_CORR_DA: cfg_next.corr_da     = coef_t'(cfg_wdata);
                REG_CORR_VA: cfg_next.corr_va     = coef_t'(cfg_wdata);
                REG_LIMIT:   cfg_next.small_limit = cfg_wdata[LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{pred_dv: '0, pred_da: '0, pred_va: '0, corr_da: '0,
                         corr_va: '0, small_limit: LIMIT_BITS'(1)};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !full;
    assign wr_en    = s_tvalid && !full;

    nmk_front u_front (
        .command         (cmd_t'(s_tuser)),
        .displacement_in (val_t'(s_tdata[VB-1:0])),
        .velocity_in     (val_t'(s_tdata[2*VB-1:VB])),
        .acceleration_in (val_t'(s_tdata[3*VB-1:2*VB])),
        .operand_value   (val_t'(s_tdata[4*VB-1:3*VB])),
        .cfg             (cfg_reg),
        .plan            (plan)
    );

    nmk_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .wr_plan    (plan),
        .full       (full),
        .rd_en      (pop),
        .head_valid (head_valid),
        .head_plan  (head_plan)
    );

    nmk_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_plan  (head_plan),
        .pop        (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .d_out      (d_out),
        .v_out      (v_out),
        .a_out      (a_out),
        .bad_out    (bad_out)
    );

    assign m_tdata = {a_out, v_out, d_out};
    assign m_tuser = bad_out;

endmodule
`default_nettype wire
